FILE: rtl/cst_pkg.sv
// shared types and constants for the connection slot table
// no dependencies
package cst_pkg;

   localparam int ENTRIES_DEF = 64;
   localparam int HANDLE_W    = 32;
   localparam int REF_W       = 9;
   localparam int INDEX_W     = 8;
   localparam int REQ_W       = 120;
   localparam int RSP_W       = 48;

   localparam logic [REF_W-1:0] REF_NONE = 9'h1FF;

   typedef enum logic [3:0] {
      OP_MAP           = 4'd0,
      OP_ATTACH_MEDIA  = 4'd1,
      OP_FREE_INDEX    = 4'd2,
      OP_FREE_CHAN     = 4'd3,
      OP_REBIND        = 4'd4,
      OP_FIND_CHAN     = 4'd5,
      OP_FIND_CTRL     = 4'd6,
      OP_CHAN_OF_INDEX = 4'd7,
      OP_MEDIA_OF_INDEX = 4'd8,
      OP_MEDIA_OF_CHAN = 4'd9,
      OP_FIND_REF      = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] chan;
      logic [HANDLE_W-1:0] media;
      logic [HANDLE_W-1:0] ctrl;
      logic [REF_W-1:0]    ref_v;
   } slot_type;

endpackage

FILE: rtl/cst_cell.sv
// one slot of the rotating slot ring
// depends on cst_pkg
module cst_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  cst_pkg::slot_type d_in,
   output cst_pkg::slot_type q_out
);
   import cst_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (shift) begin
         slot_ff <= d_in;
      end
   end

   assign q_out = slot_ff;

endmodule

FILE: rtl/connection_slot_table.sv
// connection slot table: a ring of ENTRIES slot cells rotated past one head port
// a request is accepted in ST_IDLE; ST_SCAN rotates the ring a full pass, and ST_WRITE makes
// a second pass for a map that allocates; ST_FINISH registers the result word, and a new word
// is taken only back in ST_IDLE, also while a finished result still waits on the output
// reset: synchronous, active high; clears every slot and the allocation pointer
// depends on cst_pkg and cst_cell
module connection_slot_table #(
   parameter int ENTRIES = cst_pkg::ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // op, chan_handle, sacch_handle, media_handle, ref_value, entry_index, zero pad
   input  logic [cst_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // slot_result, found, handle_out, zero pad
   output logic [cst_pkg::RSP_W-1:0] rsp_tdata
);
   import cst_pkg::*;

   localparam int CW = $clog2(ENTRIES);
   localparam logic [CW-1:0] LAST_K = CW'(ENTRIES - 1);

   slot_type cell_q [ENTRIES];
   slot_type head;
   slot_type tail;
   logic     shift;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         slot_type d;
         if (g == ENTRIES - 1) begin : g_tail
            assign d = tail;
         end else begin : g_mid
            assign d = cell_q[g+1];
         end
         cst_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d_in  (d),
            .q_out (cell_q[g])
         );
      end
   endgenerate

   assign head = cell_q[0];

   state_type               state_ff, state_in;
   logic [CW-1:0]           k_ff, k_in;
   op_type                  op_ff, op_in;
   logic [HANDLE_W-1:0]     chan_ff, chan_in, sacch_ff, sacch_in, media_ff, media_in;
   logic [REF_W-1:0]        ref_ff, ref_in;
   logic [INDEX_W-1:0]      idx_ff, idx_in;
   logic                    match_ff, match_in;
   logic [REF_W-1:0]        slot_ff, slot_in;
   logic                    found_ff, found_in;
   logic [HANDLE_W-1:0]     handle_ff, handle_in;
   logic                    hi_ff, hi_in, lo_ff, lo_in;
   logic [CW-1:0]           hi_slot_ff, hi_slot_in, lo_slot_ff, lo_slot_in;
   logic [CW-1:0]           last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic hit_chan, idx_hit;

   always_comb begin
      hit_chan = (head.chan == chan_ff);
      idx_hit  = (INDEX_W'(k_ff) == idx_ff);

      state_in     = state_ff;
      k_in         = k_ff;
      op_in        = op_ff;
      chan_in      = chan_ff;
      sacch_in     = sacch_ff;
      media_in     = media_ff;
      ref_in       = ref_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      handle_in    = handle_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      hi_slot_in   = hi_slot_ff;
      lo_slot_in   = lo_slot_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      tail         = head;
      shift        = 1'b0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = op_type'(req_tdata[3:0]);
               chan_in   = req_tdata[35:4];
               sacch_in  = req_tdata[67:36];
               media_in  = req_tdata[99:68];
               ref_in    = req_tdata[108:100];
               idx_in    = req_tdata[116:109];
               k_in      = '0;
               match_in  = 1'b0;
               slot_in   = REF_NONE;
               found_in  = 1'b0;
               handle_in = '0;
               hi_in     = 1'b0;
               lo_in     = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            shift = 1'b1;
            k_in  = (k_ff == LAST_K) ? '0 : k_ff + 1'b1;
            case (op_ff)
               OP_MAP: begin
                  if (chan_ff != '0 && !match_ff && hit_chan) begin
                     match_in = 1'b1;
                     slot_in  = REF_W'(k_ff);
                  end
                  if (head.chan == '0 && k_ff > last_ff && !hi_ff) begin
                     hi_in      = 1'b1;
                     hi_slot_in = k_ff;
                  end
                  if (head.chan == '0 && k_ff < last_ff && !lo_ff) begin
                     lo_in      = 1'b1;
                     lo_slot_in = k_ff;
                  end
               end
               OP_ATTACH_MEDIA: begin
                  if (idx_hit && head.chan != '0) begin
                     tail.media = media_ff;
                  end
               end
               OP_FREE_INDEX: begin
                  if (idx_hit && head.chan != '0) begin
                     handle_in  = head.chan;
                     tail.chan  = '0;
                     tail.media = '0;
                     tail.ctrl  = '0;
                  end
               end
               OP_FREE_CHAN: begin
                  if (chan_ff != '0 && hit_chan && !match_ff) begin
                     match_in   = 1'b1;
                     found_in   = 1'b1;
                     tail.chan  = '0;
                     tail.media = '0;
                     tail.ctrl  = '0;
                     tail.ref_v = REF_NONE;
                  end
               end
               OP_REBIND: begin
                  if (head.media == media_ff && !match_ff) begin
                     match_in = 1'b1;
                     if (!hit_chan) begin
                        tail.chan  = chan_ff;
                        tail.ctrl  = sacch_ff;
                        tail.ref_v = REF_NONE;
                        slot_in    = REF_W'(k_ff);
                     end
                  end
               end
               OP_FIND_CHAN: begin
                  if (hit_chan && !match_ff) begin
                     match_in = 1'b1;
                     slot_in  = REF_W'(k_ff);
                  end
               end
               OP_FIND_CTRL: begin
                  if (head.ctrl == sacch_ff && !match_ff) begin
                     match_in = 1'b1;
                     slot_in  = REF_W'(k_ff);
                  end
               end
               OP_CHAN_OF_INDEX: begin
                  if (idx_hit) begin
                     handle_in = head.chan;
                  end
               end
               OP_MEDIA_OF_INDEX: begin
                  if (idx_hit) begin
                     handle_in = head.media;
                  end
               end
               OP_MEDIA_OF_CHAN: begin
                  if (hit_chan && !match_ff) begin
                     match_in  = 1'b1;
                     handle_in = head.media;
                  end
               end
               OP_FIND_REF: begin
                  if (!ref_ff[REF_W-1] && head.ref_v == ref_ff && !match_ff) begin
                     match_in = 1'b1;
                     slot_in  = REF_W'(k_ff);
                  end
               end
               default: begin
               end
            endcase
            if (k_ff == LAST_K) begin
               state_in = ST_FINISH;
               if (op_ff == OP_MAP && chan_ff != '0 && !match_in && (hi_in || lo_in)) begin
                  hi_slot_in = hi_in ? hi_slot_in : lo_slot_in;
                  state_in   = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            shift = 1'b1;
            k_in  = (k_ff == LAST_K) ? '0 : k_ff + 1'b1;
            if (k_ff == hi_slot_ff) begin
               tail.chan  = chan_ff;
               tail.media = '0;
               tail.ctrl  = sacch_ff;
               tail.ref_v = ref_ff;
               last_in    = k_ff;
               slot_in    = REF_W'(k_ff);
            end
            if (k_ff == LAST_K) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, handle_ff, found_ff, slot_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      chan_ff     <= chan_in;
      sacch_ff    <= sacch_in;
      media_ff    <= media_in;
      ref_ff      <= ref_in;
      idx_ff      <= idx_in;
      match_ff    <= match_in;
      slot_ff     <= slot_in;
      found_ff    <= found_in;
      handle_ff   <= handle_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      hi_slot_ff  <= hi_slot_in;
      lo_slot_ff  <= lo_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/cst_checker.sv
// port-level checks for the connection slot table, bound to the top level
// depends on cst_pkg and connection_slot_table
module cst_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [cst_pkg::RSP_W-1:0] rsp_tdata
);
   import cst_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8:0] == REF_NONE && rsp_tdata[41:10] == '0)
      else $error("found set with slot or handle");

   a_slot_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8:0] != REF_NONE |-> !rsp_tdata[9] && rsp_tdata[41:10] == '0)
      else $error("slot result with handle or found");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result word one cycle after accept");

endmodule

bind connection_slot_table cst_checker u_cst_checker (.*);
